// ===== sv/mect_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the motor enable command retry tracker.
// Depends on nothing; every other file of the block imports it.
package mect_pkg;

    localparam int SLOTS   = 6;
    localparam int IDX_W   = 3;
    localparam int LINK_W  = 2 * SLOTS;
    localparam int TIME_W  = 32;
    localparam int CFGD_W  = 16;
    localparam int ATT_W   = 4;
    localparam int STATE_W = 4;

    localparam logic [ATT_W-1:0]   ATT_SAT      = 4'd15;
    localparam logic [STATE_W-1:0] FB_DISABLED  = 4'd0;
    localparam logic [STATE_W-1:0] FB_ENABLED   = 4'd1;
    localparam logic               FUNC_FEEDBACK = 1'b0;
    localparam logic               FUNC_STEP     = 1'b1;

    localparam logic [SLOTS-1:0]   INSTALLED_RST = 6'd59;
    localparam logic [CFGD_W-1:0]  TIMEOUT_RST   = 16'd10;
    localparam logic [CFGD_W-1:0]  RETRY_RST     = 16'd50;
    localparam logic [ATT_W-1:0]   MAX_ATT_RST   = 4'd6;

    typedef enum logic [1:0] {
        CFG_INSTALLED = 2'd0,
        CFG_TIMEOUT   = 2'd1,
        CFG_RETRY     = 2'd2,
        CFG_MAX_ATT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        LINK_UNKNOWN = 2'd0,
        LINK_DIS_OK  = 2'd1,
        LINK_EN_OK   = 2'd2,
        LINK_FAILED  = 2'd3
    } t_link;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FEEDBACK,
        S_WALK,
        S_SEND,
        S_REPORT
    } t_state;

    typedef struct packed {
        logic               req_on;
        logic               pend;
        logic               await;
        logic               fail;
        logic [ATT_W-1:0]   att;
        logic [TIME_W-1:0]  req_time;
        logic [TIME_W-1:0]  deadline;
        logic               fresh;
        logic [STATE_W-1:0] last;
        t_link              link;
    } t_slot_ent;

    typedef struct packed {
        logic             cap_in;
        logic             do_fb;
        logic             do_walk;
        logic             walk_first;
        logic [IDX_W-1:0] walk_idx;
        logic             do_send;
        logic             do_report;
    } t_dp_cmd;

    typedef struct packed {
        logic in_func;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== sv/mect_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces of the tracker: command input, result output and
// register write. Depends on mect_pkg.
interface mect_cmd_if;
    import mect_pkg::*;
    logic               valid;
    logic               ready;
    logic               func;
    logic [IDX_W-1:0]   slot;
    logic [STATE_W-1:0] reported_state;
    logic               enable_request;
    logic [TIME_W-1:0]  now_ms;
    logic               send_accepted;

    modport source (output valid, func, slot, reported_state, enable_request, now_ms,
                    send_accepted, input ready);
    modport sink (input valid, func, slot, reported_state, enable_request, now_ms,
                  send_accepted, output ready);
endinterface

interface mect_res_if;
    import mect_pkg::*;
    logic              valid;
    logic              ready;
    logic              send_valid;
    logic [IDX_W-1:0]  send_slot;
    logic              send_enable;
    logic [SLOTS-1:0]  failed_mask;
    logic              error_flag;
    logic [LINK_W-1:0] link_states;

    modport source (output valid, send_valid, send_slot, send_enable, failed_mask,
                    error_flag, link_states, input ready);
    modport sink (input valid, send_valid, send_slot, send_enable, failed_mask,
                  error_flag, link_states, output ready);
endinterface

interface mect_cfg_if;
    import mect_pkg::*;
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [CFGD_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/mect_ctrl.sv =====
`timescale 1ns / 1ps
// Controller of the tracker: sequences capture, feedback, slot walk, send, report.
// Depends on mect_pkg; drives the datapath mect_dp through t_dp_cmd.
module mect_ctrl
    import mect_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_dp_sts i_sts,
    output logic    o_cmd_ready,
    output t_dp_cmd o_cmd
);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_cnt        = '0;
                    n_state      = (i_sts.in_func == FUNC_STEP) ? S_WALK : S_FEEDBACK;
                end
            end
            S_FEEDBACK: begin
                o_cmd.do_fb = 1'b1;
                n_state     = S_REPORT;
            end
            S_WALK: begin
                o_cmd.do_walk    = 1'b1;
                o_cmd.walk_idx   = r_cnt;
                o_cmd.walk_first = (r_cnt == '0);
                if (r_cnt == IDX_W'(SLOTS - 1)) begin
                    n_state = S_SEND;
                end else begin
                    n_cnt = r_cnt + IDX_W'(1);
                end
            end
            S_SEND: begin
                o_cmd.do_send = 1'b1;
                n_state       = S_REPORT;
            end
            S_REPORT: begin
                if (i_sts.out_free) begin
                    o_cmd.do_report = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mect_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the tracker: register file, per-slot state, one shared slot
// update unit, round-robin pick and result register. Depends on mect_pkg.
module mect_dp
    import mect_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_in_func,
    input  logic [IDX_W-1:0]   i_in_slot,
    input  logic [STATE_W-1:0] i_in_fstate,
    input  logic               i_in_req,
    input  logic [TIME_W-1:0]  i_in_now,
    input  logic               i_in_acc,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [CFGD_W-1:0]  i_cfg_data,
    output logic               o_cfg_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_send_valid,
    output logic [IDX_W-1:0]   o_send_slot,
    output logic               o_send_enable,
    output logic [SLOTS-1:0]   o_failed_mask,
    output logic               o_error_flag,
    output logic [LINK_W-1:0]  o_link_states
);

    logic [SLOTS-1:0]   r_inst;
    logic [CFGD_W-1:0]  r_tmo;
    logic [CFGD_W-1:0]  r_retry;
    logic [ATT_W-1:0]   r_max_att;

    logic [IDX_W-1:0]   r_slot;
    logic [STATE_W-1:0] r_fstate;
    logic               r_req;
    logic [TIME_W-1:0]  r_now;
    logic               r_acc;

    t_slot_ent          r_ent [SLOTS];
    logic [SLOTS-1:0]   r_cand, n_cand;
    logic               r_changed, n_changed;
    logic [IDX_W-1:0]   r_next, n_next;
    logic               r_snd_valid, r_snd_en;
    logic [IDX_W-1:0]   r_snd_slot;
    logic               r_out_valid;
    logic               r_out_send_valid, r_out_send_en, r_out_err;
    logic [IDX_W-1:0]   r_out_send_slot;
    logic [SLOTS-1:0]   r_out_fmask;
    logic [LINK_W-1:0]  r_out_links;

    logic [IDX_W-1:0]   start;
    logic [IDX_W-1:0]   pick;
    logic               found;
    logic [IDX_W-1:0]   rd_idx;
    logic               rd_ok;
    t_slot_ent          rd_ent;
    t_slot_ent          n_ent;
    logic               wr_en;
    logic               cand_bit;
    logic               restarted;
    logic [SLOTS-1:0]   fmask;
    logic [LINK_W-1:0]  links;

    assign o_cfg_ready = 1'b1;
    assign o_sts.in_func  = i_in_func;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inst    <= INSTALLED_RST;
            r_tmo     <= TIMEOUT_RST;
            r_retry   <= RETRY_RST;
            r_max_att <= MAX_ATT_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_INSTALLED: r_inst    <= i_cfg_data[SLOTS-1:0];
                CFG_TIMEOUT:   r_tmo     <= i_cfg_data;
                CFG_RETRY:     r_retry   <= i_cfg_data;
                CFG_MAX_ATT:   r_max_att <= i_cfg_data[ATT_W-1:0];
                default:       r_inst    <= r_inst;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_slot   <= i_in_slot;
            r_fstate <= i_in_fstate;
            r_req    <= i_in_req;
            r_now    <= i_in_now;
            r_acc    <= i_in_acc;
        end
    end

    // Round-robin pick of due, pending slots from the resume slot (slot 0 after a restart).
    always_comb begin
        logic [IDX_W:0]   sum;
        logic [IDX_W-1:0] k;
        start = r_changed ? '0 : r_next;
        found = 1'b0;
        pick  = '0;
        for (int off = 0; off < SLOTS; off++) begin
            sum = {1'b0, start} + (IDX_W+1)'(off);
            k   = (sum >= (IDX_W+1)'(SLOTS)) ? IDX_W'(sum - (IDX_W+1)'(SLOTS))
                                               : IDX_W'(sum);
            if (!found && r_cand[k]) begin
                found = 1'b1;
                pick  = k;
            end
        end
    end

    always_comb begin
        if (i_cmd.do_send) begin
            rd_idx = pick;
        end else if (i_cmd.do_fb) begin
            rd_idx = r_slot;
        end else begin
            rd_idx = i_cmd.walk_idx;
        end
    end

    assign rd_ok  = (rd_idx < IDX_W'(SLOTS));
    assign rd_ent = rd_ok ? r_ent[rd_idx] : '0;

    // Shared slot update unit: resolve, restart, send or feedback capture for one slot.
    always_comb begin
        logic             fitted;
        logic             fb_ok;
        logic             timed_out;
        logic             retry_fail;
        logic             is_due;
        logic [ATT_W-1:0] att_inc;
        t_link            conf;
        fitted     = rd_ok && r_inst[rd_idx];
        fb_ok      = rd_ent.last == (rd_ent.req_on ? FB_ENABLED : FB_DISABLED);
        timed_out  = (r_now - rd_ent.req_time) > {{(TIME_W-CFGD_W){1'b0}}, r_tmo};
        retry_fail = rd_ent.att >= r_max_att;
        is_due     = ((r_now - rd_ent.deadline) >> (TIME_W - 1)) == '0;
        att_inc    = (rd_ent.att != ATT_SAT) ? rd_ent.att + ATT_W'(1) : rd_ent.att;
        conf       = rd_ent.req_on ? LINK_EN_OK : LINK_DIS_OK;
        n_ent      = rd_ent;
        wr_en      = 1'b0;
        cand_bit   = 1'b0;
        restarted  = 1'b0;
        if (i_cmd.do_walk) begin
            wr_en = rd_ok;
            if (!fitted) begin
                n_ent.pend  = 1'b0;
                n_ent.await = 1'b0;
                n_ent.fail  = 1'b0;
                n_ent.link  = LINK_UNKNOWN;
            end else if (rd_ent.await) begin
                if (rd_ent.fresh || timed_out) begin
                    n_ent.fresh = 1'b0;
                    if (rd_ent.fresh && fb_ok) begin
                        n_ent.await = 1'b0;
                        n_ent.pend  = 1'b0;
                        n_ent.fail  = 1'b0;
                        n_ent.link  = conf;
                    end else if (retry_fail) begin
                        n_ent.await = 1'b0;
                        n_ent.pend  = 1'b0;
                        n_ent.fail  = 1'b1;
                        n_ent.link  = LINK_FAILED;
                    end else begin
                        n_ent.pend = 1'b1;
                        n_ent.link = LINK_UNKNOWN;
                    end
                end else begin
                    n_ent.link = LINK_UNKNOWN;
                end
            end else if (rd_ent.fail) begin
                n_ent.fresh = 1'b0;
                if (rd_ent.fresh && fb_ok) begin
                    n_ent.fail = 1'b0;
                    n_ent.pend = 1'b0;
                    n_ent.link = conf;
                end else begin
                    n_ent.link = LINK_FAILED;
                end
            end
            if (fitted && (r_req != rd_ent.req_on)) begin
                restarted      = 1'b1;
                n_ent.req_on   = r_req;
                n_ent.pend     = 1'b1;
                n_ent.await    = 1'b0;
                n_ent.fail     = 1'b0;
                n_ent.att      = '0;
                n_ent.deadline = r_now;
                n_ent.fresh    = 1'b0;
                n_ent.link     = LINK_UNKNOWN;
            end
            cand_bit = fitted && n_ent.pend && (restarted || is_due);
        end else if (i_cmd.do_send) begin
            wr_en     = found;
            n_ent.att = att_inc;
            if (r_acc) begin
                n_ent.pend     = 1'b0;
                n_ent.await    = 1'b1;
                n_ent.req_time = r_now;
                n_ent.deadline = r_now + {{(TIME_W-CFGD_W){1'b0}}, r_retry};
                n_ent.link     = LINK_UNKNOWN;
            end else if (att_inc >= r_max_att) begin
                n_ent.pend  = 1'b0;
                n_ent.await = 1'b0;
                n_ent.fail  = 1'b1;
                n_ent.link  = LINK_FAILED;
            end else begin
                n_ent.deadline = r_now + {{(TIME_W-CFGD_W){1'b0}}, r_retry};
                n_ent.link     = LINK_UNKNOWN;
            end
        end else if (i_cmd.do_fb) begin
            wr_en       = rd_ok;
            n_ent.fresh = 1'b1;
            n_ent.last  = r_fstate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_ent[i].req_on <= 1'b0;
                r_ent[i].pend   <= 1'b0;
                r_ent[i].await  <= 1'b0;
                r_ent[i].fail   <= 1'b0;
                r_ent[i].fresh  <= 1'b0;
                r_ent[i].link   <= LINK_UNKNOWN;
            end
        end else if (wr_en) begin
            r_ent[rd_idx] <= n_ent;
        end
    end

    always_comb begin
        n_cand    = r_cand;
        n_changed = r_changed;
        n_next    = r_next;
        if (i_cmd.do_walk) begin
            if (i_cmd.walk_first) begin
                n_cand    = '0;
                n_changed = 1'b0;
            end
            n_cand[i_cmd.walk_idx] = cand_bit;
            n_changed              = n_changed | restarted;
        end else if (i_cmd.do_send) begin
            if (!found) begin
                n_next = start;
            end else if (pick == IDX_W'(SLOTS - 1)) begin
                n_next = '0;
            end else begin
                n_next = pick + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand    <= '0;
            r_changed <= 1'b0;
            r_next    <= '0;
        end else begin
            r_cand    <= n_cand;
            r_changed <= n_changed;
            r_next    <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_snd_valid <= 1'b0;
            r_snd_slot  <= '0;
            r_snd_en    <= 1'b0;
        end else if (i_cmd.do_send) begin
            r_snd_valid <= found;
            r_snd_slot  <= found ? pick : '0;
            r_snd_en    <= found && rd_ent.req_on;
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            fmask[i]       = r_inst[i] && r_ent[i].fail;
            links[2*i +: 2] = r_ent[i].link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.do_report) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.do_report) begin
            r_out_send_valid <= r_snd_valid;
            r_out_send_slot  <= r_snd_slot;
            r_out_send_en    <= r_snd_en;
            r_out_fmask      <= fmask;
            r_out_err        <= |fmask;
            r_out_links      <= links;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_send_valid  = r_out_send_valid;
    assign o_send_slot   = r_out_send_slot;
    assign o_send_enable = r_out_send_en;
    assign o_failed_mask = r_out_fmask;
    assign o_error_flag  = r_out_err;
    assign o_link_states = r_out_links;

endmodule

// ===== sv/motor_enable_command_retry_tracker.sv =====
`timescale 1ns / 1ps
// Motor enable command retry tracker, top level.
// Three channels, each a valid/ready interface. i_cmd carries one item per
// transaction: a feedback arrival (func 0) records the reported state of one
// slot; a control step (func 1) resolves outstanding commands, restarts slots
// whose requested enable changed, issues at most one round-robin send and
// reports the failure status. o_res returns exactly one result per item.
// i_cfg writes the four registers; it is always ready and is meant to be
// written only while no item is in flight.
// A control step passes through the slot walk, send and report states, a
// feedback item through the feedback and report states. The controller
// walks the six slots through one shared update unit, one slot per cycle,
// and takes a new item only after the last one has reached the report state.
// The result sits in an output register; a new item is taken while it waits.
// When the receiver stalls, the next result holds in the report state until
// the output register frees up. Reset is synchronous and active low; it
// clears all slot flags, restores the register defaults and empties the
// output register.
// Depends on mect_pkg, mect_if, mect_ctrl and mect_dp.
module motor_enable_command_retry_tracker
    import mect_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    mect_cmd_if.sink   i_cmd,
    mect_res_if.source o_res,
    mect_cfg_if.sink   i_cfg
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;
    logic    cmd_ready;
    logic    cfg_ready;
    logic    out_valid;

    assign i_cmd.ready = cmd_ready;
    assign i_cfg.ready = cfg_ready;
    assign o_res.valid = out_valid;

    mect_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_sts       (dp_sts),
        .o_cmd_ready (cmd_ready),
        .o_cmd       (dp_cmd)
    );

    mect_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .i_in_func     (i_cmd.func),
        .i_in_slot     (i_cmd.slot),
        .i_in_fstate   (i_cmd.reported_state),
        .i_in_req      (i_cmd.enable_request),
        .i_in_now      (i_cmd.now_ms),
        .i_in_acc      (i_cmd.send_accepted),
        .i_cfg_valid   (i_cfg.valid),
        .i_cfg_index   (i_cfg.index),
        .i_cfg_data    (i_cfg.data),
        .o_cfg_ready   (cfg_ready),
        .o_out_valid   (out_valid),
        .i_out_ready   (o_res.ready),
        .o_send_valid  (o_res.send_valid),
        .o_send_slot   (o_res.send_slot),
        .o_send_enable (o_res.send_enable),
        .o_failed_mask (o_res.failed_mask),
        .o_error_flag  (o_res.error_flag),
        .o_link_states (o_res.link_states)
    );

endmodule

// ===== sv/mect_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the tracker and the bind that attaches them.
// Depends on mect_pkg and the top level motor_enable_command_retry_tracker.
module mect_checker
    import mect_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_valid,
    input logic             i_cmd_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic             i_send_valid,
    input logic [IDX_W-1:0] i_send_slot,
    input logic [SLOTS-1:0] i_failed_mask
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("input ready while an item is in flight");

    // A new result is loaded only while the block is not taking input.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_res_valid) |-> $past(!i_cmd_ready))
        else $error("result appeared without work in progress");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_send_valid) && $stable(i_send_slot)
            && $stable(i_failed_mask))
        else $error("stalled result changed");

endmodule

bind motor_enable_command_retry_tracker mect_checker u_mect_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_send_valid  (o_res.send_valid),
    .i_send_slot   (o_res.send_slot),
    .i_failed_mask (o_res.failed_mask)
);
